FILE: rtl/core/awss_pkg.sv
// awss_pkg: shared types, constants and width helpers of the wheel speed split core
// used by awss_cordic, awss_geom and the top level; depends on nothing
package awss_pkg;

    // payload of one input beat
    typedef struct packed {
        logic signed [13:0] steer_angle;
        logic [14:0]        vehicle_speed;
    } in_beat_t;

    // payload of one result beat
    typedef struct packed {
        logic signed [23:0] front_inner_rpm;
        logic signed [23:0] front_outer_rpm;
        logic signed [23:0] rear_inner_rpm;
        logic signed [23:0] rear_outer_rpm;
        logic               clipped;
    } out_beat_t;

    // per-item flags that ride along with the geometry
    typedef struct packed {
        logic unity;   // straight ahead: ratio forced to one
        logic sneg;    // sine term negative
    } geom_flags_t;

    // configuration register indexes
    localparam logic [1:0] REG_WHEELBASE = 2'd0;
    localparam logic [1:0] REG_TRACK     = 2'd1;
    localparam logic [1:0] REG_KINGPIN   = 2'd2;
    localparam logic [1:0] REG_REAR_CG   = 2'd3;

    // reset values of the registers
    localparam logic [12:0] WHEELBASE_RST = 13'd3200;
    localparam logic [11:0] TRACK_RST     = 12'd1500;
    localparam logic [11:0] KINGPIN_RST   = 12'd1348;
    localparam logic [12:0] REAR_CG_RST   = 13'd1296;

    // rotator datapath
    localparam int CORDIC_STEPS = 29;
    localparam int XW = 33;
    localparam int ZW = 32;

    // 60/(2*pi) in Q30
    localparam logic [63:0] G_Q30 = 64'd10253479134;

    // saturation limits
    localparam logic [23:0] POS_MAX = 24'h7FFFFF;
    localparam logic [23:0] NEG_MAX = 24'h800000;

    // arctangent of 2^-i, in 2^-16 hundredths of a degree
    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:  v = 32'sd294912000;
            1:  v = 32'sd174096719;
            2:  v = 32'sd91987925;
            3:  v = 32'sd46694507;
            4:  v = 32'sd23437865;
            5:  v = 32'sd11730358;
            6:  v = 32'sd5866610;
            7:  v = 32'sd2933484;
            8:  v = 32'sd1466765;
            9:  v = 32'sd733385;
            10: v = 32'sd366693;
            11: v = 32'sd183346;
            12: v = 32'sd91673;
            13: v = 32'sd45837;
            14: v = 32'sd22918;
            15: v = 32'sd11459;
            16: v = 32'sd5730;
            17: v = 32'sd2865;
            18: v = 32'sd1432;
            19: v = 32'sd716;
            20: v = 32'sd358;
            21: v = 32'sd179;
            22: v = 32'sd90;
            23: v = 32'sd45;
            24: v = 32'sd22;
            25: v = 32'sd11;
            26: v = 32'sd6;
            27: v = 32'sd3;
            28: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // widths that follow from the fraction bit count
    function automatic int cw_of(input int f);
        return f + 3;
    endfunction

    function automatic int lcw_of(input int f);
        return f + 17;
    endfunction

    function automatic int nw_of(input int f);
        return f + 18;
    endfunction

    function automatic int aw_of(input int f);
        return f + 19;
    endfunction

    function automatic int shmax_of(input int f);
        return (f + 17 > 31) ? f + 17 - 31 : 0;
    endfunction

    function automatic int shw_of(input int f);
        return (shmax_of(f) > 0) ? $clog2(shmax_of(f) + 1) : 1;
    endfunction

endpackage

FILE: rtl/core/awss_cordic.sv
// awss_cordic: fully pipelined rotation cordic, one iteration per register stage
// depends on awss_pkg for the arctangent table and datapath widths
module awss_cordic #(
    parameter int TAG_W = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [13:0]             in_angle,
    input  logic [TAG_W-1:0]               in_tag,
    output logic                           out_valid,
    output logic signed [awss_pkg::XW-1:0] out_x,
    output logic signed [awss_pkg::XW-1:0] out_y,
    output logic [TAG_W-1:0]               out_tag
);
    localparam int N  = awss_pkg::CORDIC_STEPS;
    localparam int XW = awss_pkg::XW;
    localparam int ZW = awss_pkg::ZW;

    logic                 v_reg [N];
    logic signed [XW-1:0] x_reg [N];
    logic signed [XW-1:0] y_reg [N];
    logic signed [ZW-1:0] z_reg [N];
    logic [TAG_W-1:0]     t_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                 vi;
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic [TAG_W-1:0]     ti;

        // stage input: start vector (2^30, 0) or previous stage
        if (g == 0) begin : g_first
            assign vi = in_valid;
            assign xi = XW'(64'd1 << 30);
            assign yi = '0;
            assign zi = ZW'(signed'(in_angle)) <<< 16;
            assign ti = in_tag;
        end else begin : g_next
            assign vi = v_reg[g-1];
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
            assign ti = t_reg[g-1];
        end

        // valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= vi;
            end
        end

        // one micro-rotation toward zero residual angle
        always_ff @(posedge aclk) begin
            if (en) begin
                if (zi >= 0) begin
                    x_reg[g] <= xi - (yi >>> g);
                    y_reg[g] <= yi + (xi >>> g);
                    z_reg[g] <= zi - awss_pkg::atan_entry(g);
                end else begin
                    x_reg[g] <= xi + (yi >>> g);
                    y_reg[g] <= yi - (xi >>> g);
                    z_reg[g] <= zi + awss_pkg::atan_entry(g);
                end
                t_reg[g] <= ti;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_x     = x_reg[N-1];
    assign out_y     = y_reg[N-1];
    assign out_tag   = t_reg[N-1];

endmodule

FILE: rtl/core/awss_geom.sv
// awss_geom: six-stage turn geometry: rounds sin/cos, forms the wheel numerators
// and the scaled square sum for the cg radius; depends on awss_pkg
module awss_geom #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic signed [awss_pkg::XW-1:0]                in_x,
    input  logic signed [awss_pkg::XW-1:0]                in_y,
    input  logic [14:0]                                   in_spd,
    input  logic                                          in_zero,
    input  logic [12:0]                                   wheelbase,
    input  logic [11:0]                                   track,
    input  logic [11:0]                                   kingpin,
    input  logic [12:0]                                   rear_cg,
    output logic                                          out_valid,
    output logic [63:0]                                   out_sum,
    output logic [3:0][awss_pkg::nw_of(FRAC_BITS)-1:0]    out_n,
    output logic [awss_pkg::aw_of(FRAC_BITS)-1:0]         out_a,
    output logic [awss_pkg::shw_of(FRAC_BITS)-1:0]        out_sh,
    output awss_pkg::geom_flags_t                         out_flags
);
    localparam int CW    = awss_pkg::cw_of(FRAC_BITS);
    localparam int LCW   = awss_pkg::lcw_of(FRAC_BITS);
    localparam int NW    = awss_pkg::nw_of(FRAC_BITS);
    localparam int AW    = awss_pkg::aw_of(FRAC_BITS);
    localparam int SHMAX = awss_pkg::shmax_of(FRAC_BITS);
    localparam int SHW   = awss_pkg::shw_of(FRAC_BITS);
    localparam int XW    = awss_pkg::XW;
    localparam int RSH   = 30 - FRAC_BITS;
    localparam logic [XW-1:0] HALF = XW'(64'd1 << (29 - FRAC_BITS));
    localparam logic [63:0] GQ =
        (awss_pkg::G_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

    // stage 1: rounded cosine and sine
    logic                  v1_reg;
    logic signed [CW-1:0]  c1_reg;
    logic signed [CW-1:0]  s1_reg;
    logic signed [CW-1:0]  c1_next;
    logic signed [CW-1:0]  s1_next;
    logic [14:0]           spd1_reg;
    logic                  unity1_reg;

    assign c1_next = CW'((in_x + signed'(HALF)) >>> RSH);
    assign s1_next = CW'((in_y + signed'(HALF)) >>> RSH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg     <= c1_next;
            s1_reg     <= s1_next;
            spd1_reg   <= in_spd;
            unity1_reg <= in_zero || (s1_next == '0);
        end
    end

    // stage 2: products with the geometry registers and speed gain
    logic                  v2_reg;
    logic signed [LCW-1:0] lc2_reg;
    logic signed [LCW-1:0] ks2_reg;
    logic signed [LCW-1:0] ts2_reg;
    logic signed [LCW-1:0] rs2_reg;
    logic [AW-1:0]         a2_reg;
    awss_pkg::geom_flags_t f2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lc2_reg <= LCW'(signed'({1'b0, wheelbase, 1'b0})) * LCW'(c1_reg);
            ks2_reg <= LCW'(signed'({1'b0, kingpin})) * LCW'(s1_reg);
            ts2_reg <= LCW'(signed'({1'b0, track})) * LCW'(s1_reg);
            rs2_reg <= LCW'(signed'({1'b0, rear_cg, 1'b0})) * LCW'(s1_reg);
            a2_reg  <= AW'(spd1_reg) * AW'(GQ);
            f2_reg.unity <= unity1_reg;
            f2_reg.sneg  <= s1_reg[CW-1] && !unity1_reg;
        end
    end

    // stage 3: wheel numerators and magnitudes for the cg radius
    logic                  v3_reg;
    logic [3:0][NW-1:0]    n3_reg;
    logic [LCW-1:0]        p3_reg;
    logic [LCW-1:0]        q3_reg;
    logic [AW-1:0]         a3_reg;
    awss_pkg::geom_flags_t f3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg[0] <= NW'(lc2_reg) - NW'(ks2_reg);
            n3_reg[1] <= NW'(lc2_reg) + NW'(ks2_reg);
            n3_reg[2] <= NW'(lc2_reg) - NW'(ts2_reg);
            n3_reg[3] <= NW'(lc2_reg) + NW'(ts2_reg);
            p3_reg    <= lc2_reg[LCW-1] ? LCW'(-lc2_reg) : LCW'(lc2_reg);
            q3_reg    <= rs2_reg[LCW-1] ? LCW'(-rs2_reg) : LCW'(rs2_reg);
            a3_reg    <= a2_reg;
            f3_reg    <= f2_reg;
        end
    end

    // stage 4: common right shift that brings both terms below 2^31
    logic                  v4_reg;
    logic [SHW-1:0]        sh_next;
    logic                  sh_found;
    logic [SHW-1:0]        sh4_reg;
    logic [30:0]           pp4_reg;
    logic [30:0]           qq4_reg;
    logic [3:0][NW-1:0]    n4_reg;
    logic [AW-1:0]         a4_reg;
    awss_pkg::geom_flags_t f4_reg;

    always_comb begin
        sh_next  = '0;
        sh_found = 1'b0;
        for (int k = 0; k <= SHMAX; k++) begin
            if (!sh_found && ((64'(p3_reg) >> k) < 64'h8000_0000)
                          && ((64'(q3_reg) >> k) < 64'h8000_0000)) begin
                sh_next  = SHW'(k);
                sh_found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sh4_reg <= sh_next;
            pp4_reg <= 31'(64'(p3_reg) >> sh_next);
            qq4_reg <= 31'(64'(q3_reg) >> sh_next);
            n4_reg  <= n3_reg;
            a4_reg  <= a3_reg;
            f4_reg  <= f3_reg;
        end
    end

    // stage 5: squares
    logic                  v5_reg;
    logic [61:0]           psq5_reg;
    logic [61:0]           qsq5_reg;
    logic [SHW-1:0]        sh5_reg;
    logic [3:0][NW-1:0]    n5_reg;
    logic [AW-1:0]         a5_reg;
    awss_pkg::geom_flags_t f5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            psq5_reg <= 62'(pp4_reg) * 62'(pp4_reg);
            qsq5_reg <= 62'(qq4_reg) * 62'(qq4_reg);
            sh5_reg  <= sh4_reg;
            n5_reg   <= n4_reg;
            a5_reg   <= a4_reg;
            f5_reg   <= f4_reg;
        end
    end

    // stage 6: square sum
    logic                  v6_reg;
    logic [63:0]           sum6_reg;
    logic [SHW-1:0]        sh6_reg;
    logic [3:0][NW-1:0]    n6_reg;
    logic [AW-1:0]         a6_reg;
    awss_pkg::geom_flags_t f6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum6_reg <= 64'(psq5_reg) + 64'(qsq5_reg);
            sh6_reg  <= sh5_reg;
            n6_reg   <= n5_reg;
            a6_reg   <= a5_reg;
            f6_reg   <= f5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign out_sum   = sum6_reg;
    assign out_n     = n6_reg;
    assign out_a     = a6_reg;
    assign out_sh    = sh6_reg;
    assign out_flags = f6_reg;

endmodule

FILE: rtl/core/awss_isqrt.sv
// awss_isqrt: pipelined 64-bit floor square root, one result bit per stage
// self-contained; used by the top level for the cg radius
module awss_isqrt #(
    parameter int TAG_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      in_val,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output logic [TAG_W-1:0] out_tag
);
    localparam int N = 32;

    logic             v_reg [N];
    logic [63:0]      s_reg [N];
    logic [63:0]      r_reg [N];
    logic [TAG_W-1:0] t_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [63:0] B = 64'd1 << (62 - 2 * g);
        logic             vi;
        logic [63:0]      si;
        logic [63:0]      ri;
        logic [TAG_W-1:0] ti;
        logic [63:0]      trial;

        if (g == 0) begin : g_first
            assign vi = in_valid;
            assign si = in_val;
            assign ri = '0;
            assign ti = in_tag;
        end else begin : g_next
            assign vi = v_reg[g-1];
            assign si = s_reg[g-1];
            assign ri = r_reg[g-1];
            assign ti = t_reg[g-1];
        end

        assign trial = ri + B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= vi;
            end
        end

        // try to set this root bit
        always_ff @(posedge aclk) begin
            if (en) begin
                if (si >= trial) begin
                    s_reg[g] <= si - trial;
                    r_reg[g] <= (ri >> 1) + B;
                end else begin
                    s_reg[g] <= si;
                    r_reg[g] <= ri >> 1;
                end
                t_reg[g] <= ti;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = r_reg[N-1][31:0];
    assign out_tag   = t_reg[N-1];

endmodule

FILE: rtl/core/awss_div.sv
// awss_div: pipelined restoring divider, one quotient bit per stage
// self-contained; the top level runs one instance per wheel
module awss_div #(
    parameter int RW    = 35,
    parameter int DW    = 34,
    parameter int QB    = 39,
    parameter int TAG_W = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [RW-1:0]    in_rem,
    input  logic [QB-1:0]    in_low,
    input  logic [DW-1:0]    in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [QB-1:0]    out_quo,
    output logic [TAG_W-1:0] out_tag
);
    logic             v_reg [QB];
    logic [RW-1:0]    r_reg [QB];
    logic [QB-1:0]    l_reg [QB];
    logic [QB-1:0]    q_reg [QB];
    logic [DW-1:0]    d_reg [QB];
    logic [TAG_W-1:0] t_reg [QB];

    for (genvar g = 0; g < QB; g++) begin : g_stage
        logic             vi;
        logic [RW-1:0]    ri;
        logic [QB-1:0]    li;
        logic [QB-1:0]    qi;
        logic [DW-1:0]    di;
        logic [TAG_W-1:0] ti;
        logic [RW:0]      shifted;
        logic [RW:0]      dext;
        logic             ge;

        if (g == 0) begin : g_first
            assign vi = in_valid;
            assign ri = in_rem;
            assign li = in_low;
            assign qi = '0;
            assign di = in_den;
            assign ti = in_tag;
        end else begin : g_next
            assign vi = v_reg[g-1];
            assign ri = r_reg[g-1];
            assign li = l_reg[g-1];
            assign qi = q_reg[g-1];
            assign di = d_reg[g-1];
            assign ti = t_reg[g-1];
        end

        // bring down the next dividend bit and compare
        assign shifted = {ri, li[QB-1]};
        assign dext    = (RW + 1)'(di);
        assign ge      = shifted >= dext;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[g] <= ge ? RW'(shifted - dext) : RW'(shifted);
                l_reg[g] <= li << 1;
                q_reg[g] <= (qi << 1) | QB'(ge);
                d_reg[g] <= di;
                t_reg[g] <= ti;
            end
        end
    end

    assign out_valid = v_reg[QB-1];
    assign out_quo   = q_reg[QB-1];
    assign out_tag   = t_reg[QB-1];

endmodule

FILE: rtl/core/ackermann_wheel_speed_split_core.sv
// ackermann_wheel_speed_split_core: top level of the ackermann wheel speed split
// depends on awss_pkg, awss_cordic, awss_geom, awss_isqrt and awss_div
//
// Use: each s_ beat carries a steering angle (0.01 degree) and a vehicle speed
// (0.01 km/h); each m_ beat carries the four wheel speeds of that beat, rounded
// and saturated to 24-bit signed, with a flag that is set when any saturated.
// Exactly one result beat leaves per input beat, in order.
// Geometry comes from four registers written through cfg_wr_en, cfg_wr_idx and
// cfg_wr_data (0 wheelbase, 1 track, 2 kingpin, 3 rear cg, all in mm); write
// them only while no beat is in flight.
// The pipeline is the input register, 29 cordic stages, 6 geometry stages,
// 32 square root stages, 4 scaling stages, FRAC_BITS + 23 divider stages
// and the output register. Throughput is one beat per cycle while no result
// is held; every stage is registered and all stages advance together.
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// registers with 3200, 1500, 1348 and 1296 mm.
module ackermann_wheel_speed_split_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  awss_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output awss_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_wr_idx,
    input  logic [12:0]         cfg_wr_data
);
    localparam int NW    = awss_pkg::nw_of(FRAC_BITS);
    localparam int AW    = awss_pkg::aw_of(FRAC_BITS);
    localparam int SHMAX = awss_pkg::shmax_of(FRAC_BITS);
    localparam int SHW   = awss_pkg::shw_of(FRAC_BITS);
    localparam int DW    = 32 + SHMAX;
    localparam int MW    = NW;
    localparam int ML    = MW / 2;
    localparam int MH    = MW - ML;
    localparam int PW    = AW + MW;
    localparam int QB    = 23 + FRAC_BITS;
    localparam int RW    = DW + 1;
    localparam int CMPW  = (PW > DW + QB) ? PW : DW + QB;
    localparam int GTW   = 4 * NW + AW + SHW + 2;
    localparam logic [QB:0] RND = (QB + 1)'(64'd1 << (FRAC_BITS - 1));

    logic en;
    logic m_valid_reg;

    // whole pipeline advances unless a result is held
    assign en      = m_ready || !m_valid_reg;
    assign s_ready = en;

    // configuration registers
    logic [12:0] wheelbase_reg;
    logic [11:0] track_reg;
    logic [11:0] kingpin_reg;
    logic [12:0] rear_cg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheelbase_reg <= awss_pkg::WHEELBASE_RST;
            track_reg     <= awss_pkg::TRACK_RST;
            kingpin_reg   <= awss_pkg::KINGPIN_RST;
            rear_cg_reg   <= awss_pkg::REAR_CG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                awss_pkg::REG_WHEELBASE: wheelbase_reg <= cfg_wr_data;
                awss_pkg::REG_TRACK:     track_reg     <= cfg_wr_data[11:0];
                awss_pkg::REG_KINGPIN:   kingpin_reg   <= cfg_wr_data[11:0];
                awss_pkg::REG_REAR_CG:   rear_cg_reg   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    logic               in_v_reg;
    logic signed [13:0] ang_reg;
    logic [14:0]        spd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= s_data.steer_angle;
            spd_reg <= s_data.vehicle_speed;
        end
    end

    // angle rotation
    logic                           cor_v;
    logic signed [awss_pkg::XW-1:0] cor_x;
    logic signed [awss_pkg::XW-1:0] cor_y;
    logic [15:0]                    cor_tag;

    awss_cordic #(
        .TAG_W (16)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_v_reg),
        .in_angle  (ang_reg),
        .in_tag    ({spd_reg, ang_reg == '0}),
        .out_valid (cor_v),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_tag   (cor_tag)
    );

    // turn geometry
    logic                  geo_v;
    logic [63:0]           geo_sum;
    logic [3:0][NW-1:0]    geo_n;
    logic [AW-1:0]         geo_a;
    logic [SHW-1:0]        geo_sh;
    awss_pkg::geom_flags_t geo_f;

    awss_geom #(
        .FRAC_BITS (FRAC_BITS)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cor_v),
        .in_x      (cor_x),
        .in_y      (cor_y),
        .in_spd    (cor_tag[15:1]),
        .in_zero   (cor_tag[0]),
        .wheelbase (wheelbase_reg),
        .track     (track_reg),
        .kingpin   (kingpin_reg),
        .rear_cg   (rear_cg_reg),
        .out_valid (geo_v),
        .out_sum   (geo_sum),
        .out_n     (geo_n),
        .out_a     (geo_a),
        .out_sh    (geo_sh),
        .out_flags (geo_f)
    );

    // cg radius square root, geometry rides along
    logic                  sq_v;
    logic [31:0]           sq_root;
    logic [GTW-1:0]        sq_tag;
    logic [3:0][NW-1:0]    sq_n;
    logic [AW-1:0]         sq_a;
    logic [SHW-1:0]        sq_sh;
    awss_pkg::geom_flags_t sq_f;

    awss_isqrt #(
        .TAG_W (GTW)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_v),
        .in_val    (geo_sum),
        .in_tag    ({geo_n, geo_a, geo_sh, geo_f}),
        .out_valid (sq_v),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    assign {sq_n, sq_a, sq_sh, sq_f} = sq_tag;

    // denominator and per-wheel magnitude and sign
    logic                d_v_reg;
    logic [DW-1:0]       den_reg;
    logic [AW-1:0]       a_d_reg;
    logic [3:0][MW-1:0]  mag_reg;
    logic [3:0]          neg_d_reg;
    logic [3:0]          rail_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_v_reg <= 1'b0;
        end else if (en) begin
            d_v_reg <= sq_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= sq_f.unity ? DW'(1) : (DW'(sq_root) << sq_sh);
            a_d_reg <= sq_a;
            for (int j = 0; j < 4; j++) begin
                if (sq_f.unity) begin
                    mag_reg[j] <= MW'(1);
                end else begin
                    mag_reg[j] <= sq_n[j][NW-1] ? MW'(-sq_n[j]) : sq_n[j];
                end
                neg_d_reg[j] <= sq_f.sneg ^ (!sq_f.unity && sq_n[j][NW-1]);
                // zero cg radius: any nonzero numerator rails, whatever the speed
                rail_d_reg[j] <= !sq_f.unity && (sq_root == '0) && (sq_n[j] != '0);
            end
        end
    end

    // partial products speed*gain*magnitude
    logic                    m1_v_reg;
    logic [3:0][AW+ML-1:0]   plo_reg;
    logic [3:0][AW+MH-1:0]   phi_reg;
    logic [DW-1:0]           den1_reg;
    logic [3:0]              neg1_reg;
    logic [3:0]              rail1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
        end else if (en) begin
            m1_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                plo_reg[j] <= (AW + ML)'(a_d_reg) * (AW + ML)'(mag_reg[j][ML-1:0]);
                phi_reg[j] <= (AW + MH)'(a_d_reg) * (AW + MH)'(mag_reg[j][MW-1:ML]);
            end
            den1_reg  <= den_reg;
            neg1_reg  <= neg_d_reg;
            rail1_reg <= rail_d_reg;
        end
    end

    // full product
    logic              m2_v_reg;
    logic [3:0][PW-1:0] prod_reg;
    logic [DW-1:0]     den2_reg;
    logic [3:0]        neg2_reg;
    logic [3:0]        rail2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_v_reg <= 1'b0;
        end else if (en) begin
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                prod_reg[j] <= PW'(plo_reg[j]) + (PW'(phi_reg[j]) << ML);
            end
            den2_reg  <= den1_reg;
            neg2_reg  <= neg1_reg;
            rail2_reg <= rail1_reg;
        end
    end

    // saturation check and divider start
    logic               m3_v_reg;
    logic [3:0][RW-1:0] rem0_reg;
    logic [3:0][QB-1:0] low_reg;
    logic [DW-1:0]      den3_reg;
    logic [3:0][2:0]    lt3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_v_reg <= 1'b0;
        end else if (en) begin
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                rem0_reg[j] <= RW'(prod_reg[j] >> QB);
                low_reg[j]  <= prod_reg[j][QB-1:0];
                // {saturated, negative, zero product}
                lt3_reg[j]  <= {rail2_reg[j] || ((prod_reg[j] != '0)
                                && (CMPW'(prod_reg[j]) >= (CMPW'(den2_reg) << QB))),
                                neg2_reg[j], prod_reg[j] == '0};
            end
            den3_reg <= den2_reg;
        end
    end

    // one divider lane per wheel
    logic [3:0]          lane_v;
    logic [3:0][QB-1:0]  lane_q;
    logic [3:0][2:0]     lane_t;

    for (genvar w = 0; w < 4; w++) begin : g_lane
        awss_div #(
            .RW    (RW),
            .DW    (DW),
            .QB    (QB),
            .TAG_W (3)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (m3_v_reg),
            .in_rem    (rem0_reg[w]),
            .in_low    (low_reg[w]),
            .in_den    (den3_reg),
            .in_tag    (lt3_reg[w]),
            .out_valid (lane_v[w]),
            .out_quo   (lane_q[w]),
            .out_tag   (lane_t[w])
        );
    end

    // rounding, saturation and sign
    logic [3:0][QB:0]   rnd_sum;
    logic [3:0][23:0]   mr;
    logic [3:0][23:0]   wheel;
    logic [3:0]         clip;
    awss_pkg::out_beat_t m_data_next;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            rnd_sum[j] = (lane_t[j][0] ? '0 : (QB + 1)'(lane_q[j])) + RND;
            mr[j]      = 24'(rnd_sum[j] >> FRAC_BITS);
            clip[j]    = 1'b0;
            if (lane_t[j][2]) begin
                clip[j] = 1'b1;
                mr[j]   = lane_t[j][1] ? awss_pkg::NEG_MAX : awss_pkg::POS_MAX;
            end else if (!lane_t[j][1] && (mr[j] > awss_pkg::POS_MAX)) begin
                clip[j] = 1'b1;
                mr[j]   = awss_pkg::POS_MAX;
            end
            wheel[j] = lane_t[j][1] ? -mr[j] : mr[j];
        end
        m_data_next.front_inner_rpm = wheel[0];
        m_data_next.front_outer_rpm = wheel[1];
        m_data_next.rear_inner_rpm  = wheel[2];
        m_data_next.rear_outer_rpm  = wheel[3];
        m_data_next.clipped         = |clip;
    end

    // output register
    awss_pkg::out_beat_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= lane_v[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a flagged beat carries at least one wheel at a limit
    a_clip_has_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.clipped |->
            (m_data_reg.front_inner_rpm == awss_pkg::POS_MAX)
            || (m_data_reg.front_inner_rpm == awss_pkg::NEG_MAX)
            || (m_data_reg.front_outer_rpm == awss_pkg::POS_MAX)
            || (m_data_reg.front_outer_rpm == awss_pkg::NEG_MAX)
            || (m_data_reg.rear_inner_rpm == awss_pkg::POS_MAX)
            || (m_data_reg.rear_inner_rpm == awss_pkg::NEG_MAX)
            || (m_data_reg.rear_outer_rpm == awss_pkg::POS_MAX)
            || (m_data_reg.rear_outer_rpm == awss_pkg::NEG_MAX))
        else $error("clipped beat without a saturated wheel");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid_reg)
        else $error("result valid right after reset");

    // the four wheel lanes move in lockstep
    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_v == 4'h0) || (lane_v == 4'hF))
        else $error("divider lanes out of step");

    // a held result keeps the input side closed
    a_hold_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !s_ready)
        else $error("input accepted while a result is held");

endmodule

FILE: bench/tb_top.sv
// tb_top: self-checking bench for the ackermann wheel speed split core
// depends on awss_pkg and ackermann_wheel_speed_split_core; bit-true wheel speed predictor
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC = 16;
    localparam int LAT_WAIT = 160;

    typedef struct {
        logic signed [13:0]  ang;
        logic [14:0]         spd;
        bit                  typed;
        awss_pkg::out_beat_t want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    awss_pkg::in_beat_t  s_data;
    logic                m_valid;
    logic                m_ready;
    awss_pkg::out_beat_t m_data;
    logic                cfg_wr_en;
    logic [1:0]          cfg_wr_idx;
    logic [12:0]         cfg_wr_data;

    // geometry as the block should hold it
    logic [12:0] geo_wheelbase;
    logic [11:0] geo_track;
    logic [11:0] geo_kingpin;
    logic [12:0] geo_rear_cg;

    awss_pkg::out_beat_t wheel_speed_q[$];
    int        fails;
    int        src_idle_pct;
    int        snk_stall_pct;
    bit        hold_req;

    ackermann_wheel_speed_split_core #(.FRAC_BITS(FRAC)) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock, 12 ns period
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // run limit
    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    function automatic longint unsigned abs_mag(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // floor square root, bit by bit
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // expected wheel speeds for one beat under the current geometry
    function automatic awss_pkg::out_beat_t predict_wheels(input awss_pkg::in_beat_t b);
        longint          ang, x, y, z, dx, dy, c, s, two_lc, ks, ts, half;
        longint          n[4];
        longint unsigned spd, gq, d, p, q, pp, qq, m, qv, mv;
        logic [127:0]    prod;
        int              sh;
        bit              neg, clip;
        logic [23:0]     w[4];
        awss_pkg::out_beat_t r;
        ang = longint'(b.steer_angle);
        spd = b.vehicle_speed;
        gq = (awss_pkg::G_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
        n = '{1, 1, 1, 1};
        s = 1;
        d = 1;
        clip = 0;
        if (ang != 0) begin
            x = 64'sd1 << 30;
            y = 0;
            z = ang * 65536;
            half = 64'sd1 << (29 - FRAC);
            for (int i = 0; i < awss_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - longint'(awss_pkg::atan_entry(i));
                end else begin
                    x = x + dx; y = y - dy; z = z + longint'(awss_pkg::atan_entry(i));
                end
            end
            c = (x + half) >>> (30 - FRAC);
            s = (y + half) >>> (30 - FRAC);
            if (s == 0) begin
                // angle too small to register: straight ahead
                s = 1;
            end else begin
                two_lc = 2 * longint'(geo_wheelbase) * c;
                ks = longint'(geo_kingpin) * s;
                ts = longint'(geo_track) * s;
                n[0] = two_lc - ks;
                n[1] = two_lc + ks;
                n[2] = two_lc - ts;
                n[3] = two_lc + ts;
                p = abs_mag(two_lc);
                q = abs_mag(2 * longint'(geo_rear_cg) * s);
                sh = 0;
                while ((p >> sh) >= (64'd1 << 31) || (q >> sh) >= (64'd1 << 31)) sh++;
                pp = p >> sh;
                qq = q >> sh;
                d = floor_sqrt(pp * pp + qq * qq) << sh;
            end
        end
        for (int j = 0; j < 4; j++) begin
            m = abs_mag(n[j]);
            neg = (s < 0) != (n[j] < 0);
            if (d == 0) begin
                qv = (m != 0) ? '1 : 0;
            end else begin
                prod = 128'(spd * m) * 128'(gq);
                if (prod[127:64] >= d) qv = '1;
                else qv = 64'(prod / d);
            end
            // round and saturate
            if (qv >= (64'(awss_pkg::NEG_MAX) << FRAC)) begin
                clip = 1;
                mv = neg ? 64'(awss_pkg::NEG_MAX) : 64'(awss_pkg::POS_MAX);
            end else begin
                mv = (qv + (64'd1 << (FRAC - 1))) >> FRAC;
                if (!neg && mv > 64'(awss_pkg::POS_MAX)) begin
                    clip = 1;
                    mv = 64'(awss_pkg::POS_MAX);
                end
            end
            w[j] = neg ? 24'(-mv) : 24'(mv);
        end
        r.front_inner_rpm = w[0];
        r.front_outer_rpm = w[1];
        r.rear_inner_rpm  = w[2];
        r.rear_outer_rpm  = w[3];
        r.clipped         = clip;
        return r;
    endfunction

    // offer one beat, wait for it to be taken, then queue its expectation
    task automatic send_beat(input awss_pkg::in_beat_t b, input bit typed,
                             input awss_pkg::out_beat_t want);
        bit taken;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        taken = 0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
        wheel_speed_q.push_back(typed ? want : predict_wheels(b));
    endtask

    task automatic send_row(input stim_row_t row);
        awss_pkg::in_beat_t b;
        b.steer_angle   = row.ang;
        b.vehicle_speed = row.spd;
        send_beat(b, row.typed, row.want);
    endtask

    // let every result drain, then allow the pipeline to settle
    task automatic drain;
        s_valid <= 1'b0;
        wait (wheel_speed_q.size() == 0);
        repeat (LAT_WAIT) @(posedge aclk);
    endtask

    // write all four registers, one per cycle
    task automatic set_geometry(input logic [12:0] wb, input logic [12:0] tr,
                                input logic [12:0] kp, input logic [12:0] cg);
        logic [12:0] vals[4];
        logic [1:0]  idx[4];
        vals = '{wb, tr, kp, cg};
        idx  = '{awss_pkg::REG_WHEELBASE, awss_pkg::REG_TRACK,
                 awss_pkg::REG_KINGPIN, awss_pkg::REG_REAR_CG};
        for (int i = 0; i < 4; i++) begin
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_idx  <= idx[i];
            cfg_wr_data <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        geo_wheelbase = wb;
        geo_track     = tr[11:0];
        geo_kingpin   = kp[11:0];
        geo_rear_cg   = cg;
    endtask

    // result side: random stalls, long hold on request, field checks
    initial begin
        int hold_left;
        awss_pkg::out_beat_t want;
        hold_left = 0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
            @(negedge aclk);
            if (m_valid && m_ready) begin
                if (wheel_speed_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    fails++;
                end else begin
                    want = wheel_speed_q.pop_front();
                    if (m_data.front_inner_rpm !== want.front_inner_rpm) begin
                        $error("front_inner_rpm exp %0d got %0d",
                               want.front_inner_rpm, m_data.front_inner_rpm);
                        fails++;
                    end
                    if (m_data.front_outer_rpm !== want.front_outer_rpm) begin
                        $error("front_outer_rpm exp %0d got %0d",
                               want.front_outer_rpm, m_data.front_outer_rpm);
                        fails++;
                    end
                    if (m_data.rear_inner_rpm !== want.rear_inner_rpm) begin
                        $error("rear_inner_rpm exp %0d got %0d",
                               want.rear_inner_rpm, m_data.rear_inner_rpm);
                        fails++;
                    end
                    if (m_data.rear_outer_rpm !== want.rear_outer_rpm) begin
                        $error("rear_outer_rpm exp %0d got %0d",
                               want.rear_outer_rpm, m_data.rear_outer_rpm);
                        fails++;
                    end
                    if (m_data.clipped !== want.clipped) begin
                        $error("clipped exp %0b got %0b", want.clipped, m_data.clipped);
                        fails++;
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        stim_row_t edge_rows[$];
        stim_row_t flat_rows[$];
        logic [12:0] geo_sets[5][4];
        awss_pkg::out_beat_t zero_out, rail_out;
        awss_pkg::in_beat_t b;

        zero_out = '0;
        rail_out = {awss_pkg::NEG_MAX, awss_pkg::POS_MAX, awss_pkg::NEG_MAX,
                    awss_pkg::POS_MAX, 1'b1};
        // extremes of angle and speed under the reset geometry
        edge_rows = '{
            '{14'sd0,     15'd0,     1, zero_out},
            '{14'sd0,     15'd20000, 0, zero_out},
            '{14'sd0,     15'd32767, 0, zero_out},
            '{14'sd1,     15'd15000, 0, zero_out},
            '{-14'sd1,    15'd15000, 0, zero_out},
            '{14'sd4500,  15'd10000, 0, zero_out},
            '{-14'sd4500, 15'd10000, 0, zero_out},
            '{14'sd100,   15'd0,     0, zero_out},
            '{-14'sd2000, 15'd20000, 0, zero_out},
            '{14'sd3000,  15'd32767, 0, zero_out},
            '{14'sd6000,  15'd5000,  0, zero_out},
            '{14'sd9000,  15'd20000, 0, zero_out},
            '{14'sd8191,  15'd32767, 0, zero_out},
            '{-14'sd8192, 15'd32767, 0, zero_out},
            '{-14'sd7000, 15'd12345, 0, zero_out},
            '{14'sd5461,  15'd21845, 0, zero_out},
            '{-14'sd5462, 15'd10922, 0, zero_out}
        };
        // zero wheelbase and zero rear cg: every wheel rails when steered, straight ahead gives zero
        flat_rows = '{
            '{14'sd1500,  15'd8000, 1, rail_out},
            '{-14'sd1500, 15'd0,    1, rail_out},
            '{14'sd0,     15'd0,    1, zero_out}
        };
        geo_sets = '{
            '{13'd500,  13'd500,  13'd500,  13'd0},
            '{13'd8000, 13'd3000, 13'd3000, 13'd8000},
            '{13'd8191, 13'h1FFF, 13'h1FFF, 13'd8191},
            '{13'd2750, 13'd1620, 13'd1400, 13'd1100},
            '{13'd3200, 13'd1500, 13'd1348, 13'd1296}
        };

        fails = 0;
        hold_req = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_idx = awss_pkg::REG_WHEELBASE;
        cfg_wr_data = '0;
        geo_wheelbase = awss_pkg::WHEELBASE_RST;
        geo_track     = awss_pkg::TRACK_RST;
        geo_kingpin   = awss_pkg::KINGPIN_RST;
        geo_rear_cg   = awss_pkg::REAR_CG_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (edge_rows[i]) send_row(edge_rows[i]);
        drain();

        set_geometry(13'd0, 13'd1500, 13'd1348, 13'd0);
        foreach (flat_rows[i]) send_row(flat_rows[i]);
        drain();

        // random phases across geometries and idle patterns
        for (int ph = 0; ph < 5; ph++) begin
            set_geometry(geo_sets[ph][0], geo_sets[ph][1], geo_sets[ph][2], geo_sets[ph][3]);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                default: begin src_idle_pct = 15; snk_stall_pct = 15; end
            endcase
            if (ph == 4) begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
                hold_req = 1;
            end
            for (int k = 0; k < 80; k++) begin
                if ($urandom_range(9) < 7) begin
                    b.steer_angle   = 14'($signed($urandom_range(9000)) - 4500);
                    b.vehicle_speed = 15'($urandom_range(20000));
                end else begin
                    b.steer_angle   = 14'($urandom);
                    b.vehicle_speed = 15'($urandom);
                end
                send_beat(b, 0, zero_out);
            end
            drain();
        end

        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
